/* rtl/tdmb_pkg.sv */
// shared constants and types for the moving-baseline touch detector
package tdmb_pkg;

	localparam int SAMPLE_W             = 18;
	localparam int ENTRY_W              = 17;
	localparam int RISE_W               = 16;
	localparam int FALL_W               = 17;
	localparam int CFG_DATA_W           = 17;
	localparam int CFG_IDX_W            = 2;
	localparam int SUM_OUT_W            = 21;
	localparam int DEFAULT_WINDOW_DEPTH = 16;
	localparam int RISE_RESET           = 200;
	localparam int FALL_RESET           = 0;

	localparam logic [SUM_OUT_W-1:0] SUM_OUT_MAX = {SUM_OUT_W{1'b1}};

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RISE_THRESHOLD = 2'd0,
		CFG_FALL_MARGIN    = 2'd1
	} cfg_idx_t;

endpackage

/* rtl/tdmb_window.sv */
// sample window shift line and running window sum
module tdmb_window #(
	parameter int WINDOW_DEPTH = tdmb_pkg::DEFAULT_WINDOW_DEPTH,
	parameter int SUM_W        = tdmb_pkg::SUM_OUT_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [tdmb_pkg::ENTRY_W-1:0] push_value,
	output logic [SUM_W-1:0]            sum_next
);
	import tdmb_pkg::*;

	logic [ENTRY_W-1:0] taps_q [WINDOW_DEPTH];
	logic [SUM_W-1:0]   sum_q;

	// oldest entry leaves at the far end of the line
	always_comb begin
		if (push) begin
			sum_next = sum_q - SUM_W'(taps_q[WINDOW_DEPTH-1]) + SUM_W'(push_value);
		end else begin
			sum_next = sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				taps_q[i] <= '0;
			end
			sum_q <= '0;
		end else if (push) begin
			taps_q[0] <= push_value;
			for (int i = 1; i < WINDOW_DEPTH; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
			sum_q <= sum_next;
		end
	end

endmodule

/* rtl/touch_detect_moving_baseline.sv */
// top level of the moving-baseline touch detector with threshold and hysteresis
// a word accepted is held in the stage-1 registers, then its result is written to the output register
// throughput: one word per cycle while results are taken, the window sum and compare close in a single stage
// the output register lets a new word in while a finished result waits to be taken
// reset clears the window, the sum and the saved sum, arms the detector, and loads
// rise threshold 200 and fall margin 0; no clearing pass is needed
module touch_detect_moving_baseline #(
	parameter int WINDOW_DEPTH = tdmb_pkg::DEFAULT_WINDOW_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input word channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [tdmb_pkg::SAMPLE_W-1:0] sample,
	// result word channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             touch_detected,
	output logic                             armed_now,
	output logic [tdmb_pkg::SUM_OUT_W-1:0]   baseline_sum,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tdmb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tdmb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tdmb_pkg::*;

	// width of the window depth as a number
	localparam int NW    = $clog2(WINDOW_DEPTH + 1);
	// exact window sum width
	localparam int SUM_W = ENTRY_W + $clog2(WINDOW_DEPTH);
	// width used for the saturation compare
	localparam int SAT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;
	// scaled threshold widths
	localparam int RS_W  = RISE_W + NW;
	localparam int FS_W  = FALL_W + NW;
	// signed width of the scaled margins
	localparam int DW    = SAMPLE_W + NW + 2;

	localparam logic signed [DW-1:0]   N_D = DW'(WINDOW_DEPTH);
	localparam logic [RS_W-1:0]        N_R = RS_W'(WINDOW_DEPTH);
	localparam logic signed [FS_W-1:0] N_F = FS_W'(WINDOW_DEPTH);

	// configuration, kept already scaled by the window depth
	logic [RS_W-1:0]        rise_sc_q;
	logic signed [FS_W-1:0] fall_sc_q;
	logic [RS_W-1:0]        rise_sc_d;
	logic signed [FS_W-1:0] fall_x;
	logic signed [FS_W-1:0] fall_sc_d;

	assign cfg_ready = 1'b1;
	assign rise_sc_d = RS_W'(cfg_data[RISE_W-1:0]) * N_R;
	assign fall_x    = FS_W'($signed(cfg_data[FALL_W-1:0]));
	assign fall_sc_d = fall_x * N_F;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_sc_q <= RS_W'(RISE_RESET * WINDOW_DEPTH);
			fall_sc_q <= FS_W'(FALL_RESET * WINDOW_DEPTH);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RISE_THRESHOLD: begin
					rise_sc_q <= rise_sc_d;
				end
				CFG_FALL_MARGIN: begin
					fall_sc_q <= fall_sc_d;
				end
				default: begin
					// unknown index, write dropped
				end
			endcase
		end
	end

	// input stage: sample*N with the thresholds already taken off
	// touch when rise_margin > sum, re-arm when fall_margin <= saved sum
	logic signed [DW-1:0] sample_x;
	logic signed [DW-1:0] scaled_sample;
	logic signed [DW-1:0] rise_margin;
	logic signed [DW-1:0] fall_margin;

	assign sample_x      = DW'(sample);
	assign scaled_sample = sample_x * N_D;
	assign rise_margin   = scaled_sample - $signed(DW'(rise_sc_q));
	assign fall_margin   = scaled_sample - DW'(fall_sc_q);

	logic                 valid_s1;
	logic                 pos_s1;
	logic [ENTRY_W-1:0]   entry_s1;
	logic signed [DW-1:0] rise_margin_s1;
	logic signed [DW-1:0] fall_margin_s1;
	logic                 advance;

	// stage 1 moves whenever the output register is free or being emptied
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pos_s1         <= !sample[SAMPLE_W-1] && (sample != '0);
			entry_s1       <= sample[ENTRY_W-1:0];
			rise_margin_s1 <= rise_margin;
			fall_margin_s1 <= fall_margin;
		end
	end

	// commit stage: window update, compare and detector state
	logic                 commit;
	logic                 push;
	logic [SUM_W-1:0]     sum_next;
	logic signed [DW-1:0] sum_cmp;
	logic signed [DW-1:0] saved_cmp;
	logic [SUM_W-1:0]     saved_sum_q;
	logic                 armed_q;
	logic                 touch;
	logic                 armed_next;
	logic [SAT_W-1:0]     sum_wide;
	logic [SUM_OUT_W-1:0] sum_shown;

	assign commit = valid_s1 && advance;
	// timeouts (zero or negative) never enter the window
	assign push   = commit && pos_s1;

	tdmb_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SUM_W        (SUM_W)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_value (entry_s1),
		.sum_next   (sum_next)
	);

	assign sum_cmp   = $signed(DW'(sum_next));
	assign saved_cmp = $signed(DW'(saved_sum_q));

	always_comb begin
		touch      = 1'b0;
		armed_next = armed_q;
		// empty baseline: no decision at all
		if (sum_next != '0) begin
			if (armed_q) begin
				if (rise_margin_s1 > sum_cmp) begin
					touch      = 1'b1;
					armed_next = 1'b0;
				end
			end else begin
				if (fall_margin_s1 <= saved_cmp) begin
					armed_next = 1'b1;
				end
			end
		end
	end

	// saturate the shown sum for deep windows
	assign sum_wide  = SAT_W'(sum_next);
	assign sum_shown = (sum_wide > SAT_W'(SUM_OUT_MAX)) ? SUM_OUT_MAX
		: sum_wide[SUM_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b1;
			saved_sum_q <= '0;
		end else if (commit) begin
			armed_q <= armed_next;
			// baseline remembered at the touch, read back while disarmed
			if (touch) begin
				saved_sum_q <= sum_next;
			end
		end
	end

	// output register
	logic                 out_valid_q;
	logic                 touch_q;
	logic                 armed_out_q;
	logic [SUM_OUT_W-1:0] baseline_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			touch_q     <= touch;
			armed_out_q <= armed_next;
			baseline_q  <= sum_shown;
		end
	end

	assign out_valid      = out_valid_q;
	assign touch_detected = touch_q;
	assign armed_now      = armed_out_q;
	assign baseline_sum   = baseline_q;

endmodule

/* tb/tb_touch_detect_moving_baseline.sv */
// self-checking testbench for the moving-baseline touch detector
module tb_touch_detect_moving_baseline;

	import tdmb_pkg::*;

	localparam int DEPTH       = DEFAULT_WINDOW_DEPTH;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 4;      // extra wait after the last expected result word
	localparam int PHASE_WORDS = 220;
	localparam int HOLD_CYCLES = 120;

	// indexes with no register behind them, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 18'h1FFFF;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 18'h20000;

	typedef struct packed {
		logic                 touch;
		logic                 armed;
		logic [SUM_OUT_W-1:0] sum;
	} touch_result_t;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [SAMPLE_W-1:0]   smp;
		logic                  typed;   // want holds a hand-written result
		touch_result_t         want;
	} stim_row_t;

	// dut ports
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic signed [SAMPLE_W-1:0]  sample = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic                        touch_detected;
	logic                        armed_now;
	logic [SUM_OUT_W-1:0]        baseline_sum;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;

	// predictor state: the window, its running sum and the arm latch
	logic [ENTRY_W-1:0]          base_window [DEPTH];
	longint                      base_sum;
	int                          wr_ptr;
	logic                        is_armed;
	longint                      touch_sum;
	logic [RISE_W-1:0]           rise_cnt;
	logic signed [FALL_W-1:0]    fall_cnt;

	touch_result_t               expected_touch_q [$];
	stim_row_t                   directed_rows [$];

	int                          mismatch_cnt = 0;
	int                          cycle_cnt = 0;
	int                          idle_pct = 0;
	int                          stall_pct = 0;
	int                          hold_cnt = 0;
	int                          hold_req = 0;
	int                          hold_done = 0;

	touch_detect_moving_baseline #(
		.WINDOW_DEPTH(DEPTH)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.touch_detected(touch_detected),
		.armed_now     (armed_now),
		.baseline_sum  (baseline_sum),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 12-unit clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side back-pressure; a long hold wins over the random stall
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt = hold_cnt - 1;
			out_ready <= 1'b0;
		end else if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_cnt  = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic check_field(string what, longint want, longint got);
		if (want != got) begin
			mismatch_cnt++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// every result word taken is matched against the oldest expectation
	always @(posedge clk) begin
		touch_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_touch_q.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: result word with nothing expected, actual touch %0d armed %0d sum %0d",
					$time, touch_detected, armed_now, baseline_sum);
			end else begin
				exp_res = expected_touch_q.pop_front();
				check_field("touch_detected", exp_res.touch, touch_detected);
				check_field("armed_now", exp_res.armed, armed_now);
				check_field("baseline_sum", exp_res.sum, baseline_sum);
			end
		end
	end

	// predictor: ring update, then the cross-multiplied threshold compares
	function automatic touch_result_t advance_baseline(logic signed [SAMPLE_W-1:0] s);
		longint        sv;
		longint        lhs;
		longint        rhs;
		touch_result_t res;
		sv = longint'(s);
		// timeouts never enter the window but still take part in the compare
		if (sv > 0) begin
			base_sum = base_sum - base_window[wr_ptr] + sv;
			base_window[wr_ptr] = sv[ENTRY_W-1:0];
			wr_ptr = (wr_ptr + 1) % DEPTH;
		end
		res.touch = 1'b0;
		// empty baseline: no compare at all, arm state held
		if (base_sum != 0) begin
			lhs = sv * DEPTH;
			if (is_armed) begin
				rhs = base_sum + longint'(rise_cnt) * DEPTH;
				if (lhs > rhs) begin
					res.touch = 1'b1;
					touch_sum = base_sum;
					is_armed  = 1'b0;
				end
			end else begin
				// saved sum is only looked at while disarmed
				rhs = touch_sum + longint'(fall_cnt) * DEPTH;
				if (lhs <= rhs)
					is_armed = 1'b1;
			end
		end
		res.armed = is_armed;
		res.sum   = (base_sum > longint'(SUM_OUT_MAX)) ? SUM_OUT_MAX : base_sum[SUM_OUT_W-1:0];
		return res;
	endfunction

	function automatic stim_row_t word_row(logic [SAMPLE_W-1:0] s);
		stim_row_t r;
		r       = '0;
		r.kind  = ROW_WORD;
		r.smp   = s;
		return r;
	endfunction

	function automatic stim_row_t checked_row(logic [SAMPLE_W-1:0] s, logic t, logic a,
		logic [SUM_OUT_W-1:0] bs);
		stim_row_t r;
		r       = word_row(s);
		r.typed = 1'b1;
		r.want  = '{touch: t, armed: a, sum: bs};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_CFG;
		r.idx  = idx;
		r.data = d;
		return r;
	endfunction

	// offer one word, random gaps first, and predict once it is taken
	task automatic send_word(logic [SAMPLE_W-1:0] s, logic typed, touch_result_t want);
		touch_result_t res;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		res = advance_baseline(s);
		expected_touch_q.push_back(typed ? want : res);
	endtask

	// stop offering and wait until every result word has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_touch_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_RISE_THRESHOLD)
			rise_cnt = d[RISE_W-1:0];
		else if (idx == CFG_FALL_MARGIN)
			fall_cnt = d;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly samples around a baseline level, with spikes above it, timeouts and noise
	function automatic logic [SAMPLE_W-1:0] pick_sample(int level, int rise);
		int r;
		int v;
		int nz;
		r  = $urandom_range(99);
		nz = rise / 2 + 8;
		if (r < 60) begin
			v = level + int'($urandom_range(2 * nz)) - nz;
			if (v < 1)
				v = 1;
			if (v > 131071)
				v = 131071;
		end else if (r < 75) begin
			v = level + rise + int'($urandom_range(4000, 1));
			if (v > 131071)
				v = 131071;
		end else if (r < 85) begin
			v = -int'($urandom_range(131072));
		end else begin
			v = int'($urandom_range(262143));
		end
		return v[SAMPLE_W-1:0];
	endfunction

	initial begin
		int            level;
		int            rise_pick;
		logic [FALL_W-1:0] fall_pick;
		touch_result_t none;

		none = '0;

		// predictor reset values match the block's reset
		foreach (base_window[i])
			base_window[i] = '0;
		base_sum  = 0;
		wr_ptr    = 0;
		is_armed  = 1'b1;
		touch_sum = 0;
		rise_cnt  = RISE_W'(RISE_RESET);
		fall_cnt  = FALL_W'(FALL_RESET);

		// directed words, the typed results assume rise 200 and fall 0 after reset
		directed_rows.push_back(checked_row(18'd0, 1'b0, 1'b1, 21'd0));
		directed_rows.push_back(checked_row(SAMPLE_MIN, 1'b0, 1'b1, 21'd0));
		directed_rows.push_back(checked_row(18'd100, 1'b0, 1'b1, 21'd100));
		directed_rows.push_back(checked_row(SAMPLE_MAX, 1'b1, 1'b0, 21'd131171));
		// disarmed, sample far above the saved baseline keeps it disarmed
		directed_rows.push_back(checked_row(SAMPLE_MAX, 1'b0, 1'b0, 21'd262242));
		// timeout while disarmed still re-arms through its signed value
		directed_rows.push_back(checked_row(-18'sd5, 1'b0, 1'b1, 21'd262242));
		directed_rows.push_back(checked_row(18'd1, 1'b0, 1'b1, 21'd262243));
		// writes past the last register must leave the threshold at 200
		directed_rows.push_back(cfg_row(CFG_SPARE_LO, 17'h00000));
		directed_rows.push_back(cfg_row(CFG_SPARE_HI, 17'h1FFFF));
		directed_rows.push_back(checked_row(SAMPLE_MAX, 1'b1, 1'b0, 21'd393314));
		// zero threshold and the most negative margin
		directed_rows.push_back(cfg_row(CFG_RISE_THRESHOLD, 17'h00000));
		directed_rows.push_back(cfg_row(CFG_FALL_MARGIN, 17'h10000));
		directed_rows.push_back(word_row(-18'sd1));
		directed_rows.push_back(word_row(SAMPLE_MIN));
		directed_rows.push_back(word_row(18'd24582));
		directed_rows.push_back(word_row(18'd24583));
		// widest threshold, bit 16 of the data is dropped, and the widest margin
		directed_rows.push_back(cfg_row(CFG_RISE_THRESHOLD, 17'h1FFFF));
		directed_rows.push_back(cfg_row(CFG_FALL_MARGIN, 17'h0FFFF));
		directed_rows.push_back(word_row(SAMPLE_MAX));
		directed_rows.push_back(word_row(18'd2));
		directed_rows.push_back(word_row(18'd65536));
		directed_rows.push_back(word_row(SAMPLE_MAX));
		directed_rows.push_back(word_row(18'd0));
		directed_rows.push_back(word_row(SAMPLE_MAX));

		// reset once, released on a falling edge
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_word(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		// random phases: none, sender gaps, receiver stalls, both, then pressure
		for (int p = 0; p < 5; p++) begin
			drain();
			case (p)
				0: begin
					rise_pick = 0;
					fall_pick = 17'h10000;
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					rise_pick = 65535;
					fall_pick = 17'h0FFFF;
					idle_pct  = 80;
					stall_pct = 0;
				end
				2: begin
					rise_pick = $urandom_range(3000);
					fall_pick = 17'($urandom_range(131071));
					idle_pct  = 0;
					stall_pct = 80;
				end
				3: begin
					rise_pick = $urandom_range(65535);
					fall_pick = 17'($urandom_range(131071));
					idle_pct  = 29;
					stall_pct = 29;
				end
				default: begin
					rise_pick = $urandom_range(2000);
					fall_pick = 17'($urandom_range(4000));
					idle_pct  = 0;
					stall_pct = 0;
				end
			endcase
			// random top bit on the threshold data, it must be ignored
			write_reg(CFG_RISE_THRESHOLD, {1'($urandom_range(1)), 16'(rise_pick)});
			write_reg(CFG_FALL_MARGIN, fall_pick);
			level = $urandom_range(40000, 1);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if (p == 4 && (k == 40 || k == 140))
					hold_req++;   // block fills and must stall its input
				if (p == 4 && k == 100)
					drain();
				if ($urandom_range(49) == 0)
					level = $urandom_range(40000, 1);
				send_word(pick_sample(level, rise_cnt), 1'b0, none);
			end
		end

		drain();

		if (mismatch_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
rtl/tdmb_pkg.sv
rtl/tdmb_window.sv
rtl/touch_detect_moving_baseline.sv
tb/tb_touch_detect_moving_baseline.sv
